[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // quotient bits per part: 32-bit magnitude numerator shifted up by 16
  localparam int QW = 48;
  localparam int DW = 32;

  typedef enum logic [1:0] {
    ACT_SUB = 2'd0,
    ACT_MUL = 2'd1,
    ACT_DIV = 2'd2,
    ACT_RSV = 2'd3
  } cau_action_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 err;
    logic                 neg_r;
    logic                 neg_i;
    logic [DW-1:0]        den;
    logic [DW-1:0]        rem_r;
    logic [DW-1:0]        rem_i;
    logic [QW-1:0]        dvd_r;
    logic [QW-1:0]        dvd_i;
    logic signed [31:0]   pass_r;
    logic signed [31:0]   pass_i;
  } cau_cell_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // saturate a quotient magnitude with its sign to a signed 32-bit value
  function automatic logic signed [31:0] satq(input logic [QW-1:0] mag, input logic neg);
    if (neg) begin
      if (mag > QW'(64'h80000000)) begin
        return 32'sh80000000;
      end
      return 32'(-mag);
    end
    if (mag > QW'(64'h7fffffff)) begin
      return 32'sh7fffffff;
    end
    return mag[31:0];
  endfunction

endpackage

[sv/complex_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex subtract, multiply and divide of Q8.8 operands to Q16.16 results.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled. A request
// passes through two front stages (products, then sums and divisor), a chain
// of 48 division cells that each settle one quotient bit of both parts, and
// the output register. Every operation travels the same chain, so results
// leave in request order. A stall on the output holds the whole pipeline.
module complex_arithmetic_unit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_a_real,
  input  logic signed [15:0] in_a_imag,
  input  logic signed [15:0] in_b_real,
  input  logic signed [15:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic               out_divide_error
);

  logic                 adv;
  cau_pkg::cau_cell_t   chain [0:cau_pkg::QW];
  logic                 out_valid_r;
  logic signed [31:0]   res_r_r, res_i_r;
  logic                 err_r;
  logic signed [31:0]   res_r_nxt, res_i_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_a_real (in_a_real),
    .in_a_imag (in_a_imag),
    .in_b_real (in_b_real),
    .in_b_imag (in_b_imag),
    .q         (chain[0])
  );

  for (genvar g = 0; g < cau_pkg::QW; g++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  always_comb begin
    if (chain[cau_pkg::QW].is_div) begin
      res_r_nxt = cau_pkg::satq(chain[cau_pkg::QW].dvd_r, chain[cau_pkg::QW].neg_r);
      res_i_nxt = cau_pkg::satq(chain[cau_pkg::QW].dvd_i, chain[cau_pkg::QW].neg_i);
    end else begin
      res_r_nxt = chain[cau_pkg::QW].pass_r;
      res_i_nxt = chain[cau_pkg::QW].pass_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[cau_pkg::QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r_r <= res_r_nxt;
      res_i_r <= res_i_nxt;
      err_r   <= chain[cau_pkg::QW].err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_real  = res_r_r;
  assign out_result_imag  = res_i_r;
  assign out_divide_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> res_r_r == 32'sd0 && res_i_r == 32'sd0)
    else $error("divide error with nonzero result");

  a_load_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("output loaded while pipeline held");

  a_err_not_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> !$past(chain[cau_pkg::QW].is_div) || $past(!adv))
    else $error("divide error on a live division");

endmodule

[sv/cau_cell.sv]
// ----------------------------------------------------------------------------
// cau_cell
// One restoring division step for both parts: one quotient bit per cell.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  cau_pkg::cau_cell_t d,
  output cau_pkg::cau_cell_t q
);

  cau_pkg::cau_cell_t q_r;
  cau_pkg::cau_cell_t q_nxt;
  logic [cau_pkg::DW:0] t_r;
  logic [cau_pkg::DW:0] t_i;
  logic [cau_pkg::DW:0] den_x;
  logic                 ge_r;
  logic                 ge_i;

  always_comb begin
    den_x = {1'b0, d.den};
    t_r   = {d.rem_r, d.dvd_r[cau_pkg::QW-1]};
    t_i   = {d.rem_i, d.dvd_i[cau_pkg::QW-1]};
    ge_r  = (t_r >= den_x);
    ge_i  = (t_i >= den_x);
    q_nxt = d;
    q_nxt.rem_r = ge_r ? cau_pkg::DW'(t_r - den_x) : t_r[cau_pkg::DW-1:0];
    q_nxt.rem_i = ge_i ? cau_pkg::DW'(t_i - den_x) : t_i[cau_pkg::DW-1:0];
    q_nxt.dvd_r = {d.dvd_r[cau_pkg::QW-2:0], ge_r};
    q_nxt.dvd_i = {d.dvd_i[cau_pkg::QW-2:0], ge_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[sv/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Product stage and operand preparation ahead of the divider chain.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_a_real,
  input  logic signed [15:0] in_a_imag,
  input  logic signed [15:0] in_b_real,
  input  logic signed [15:0] in_b_imag,
  output cau_pkg::cau_cell_t q
);

  logic                      va_r;
  cau_pkg::cau_action_t      act_r;
  logic signed [31:0]        p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [16:0]        dr_r, di_r;

  logic signed [32:0]        nr, ni, mr, mi;
  logic [31:0]               den;
  cau_pkg::cau_cell_t        q_r;
  cau_pkg::cau_cell_t        q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r  <= in_valid;
      act_r <= cau_pkg::cau_action_t'(in_action);
      p0_r  <= in_a_real * in_b_real;
      p1_r  <= in_a_imag * in_b_imag;
      p2_r  <= in_a_real * in_b_imag;
      p3_r  <= in_a_imag * in_b_real;
      p4_r  <= in_b_real * in_b_real;
      p5_r  <= in_b_imag * in_b_imag;
      dr_r  <= 17'(in_a_real) - 17'(in_b_real);
      di_r  <= 17'(in_a_imag) - 17'(in_b_imag);
    end
  end

  always_comb begin
    mr  = 33'(p0_r) - 33'(p1_r);
    mi  = 33'(p2_r) + 33'(p3_r);
    nr  = 33'(p0_r) + 33'(p1_r);
    ni  = 33'(p3_r) - 33'(p2_r);
    den = $unsigned(p4_r) + $unsigned(p5_r);

    q_nxt        = '0;
    q_nxt.valid  = va_r;
    q_nxt.den    = den;
    q_nxt.neg_r  = nr[32];
    q_nxt.neg_i  = ni[32];
    q_nxt.dvd_r  = {(nr[32] ? 32'(-nr) : nr[31:0]), 16'd0};
    q_nxt.dvd_i  = {(ni[32] ? 32'(-ni) : ni[31:0]), 16'd0};
    case (act_r)
      cau_pkg::ACT_SUB: begin
        q_nxt.pass_r = {{7{dr_r[16]}}, dr_r, 8'd0};
        q_nxt.pass_i = {{7{di_r[16]}}, di_r, 8'd0};
      end
      cau_pkg::ACT_MUL: begin
        q_nxt.pass_r = cau_pkg::sat33(mr);
        q_nxt.pass_i = cau_pkg::sat33(mi);
      end
      cau_pkg::ACT_DIV: begin
        // zero divisor: zero parts and flag
        q_nxt.is_div = (den != 32'd0);
        q_nxt.err    = (den == 32'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
